// ===== sv/mecwb_pkg.sv =====
package mecwb_pkg;

   // default sizes of the word table
   localparam int DICT_WORDS_DEF = 32;
   localparam int WORD_LEN_DEF = 16;

   // saturation point of the running cost
   localparam logic [15:0] COST_MAX = 16'hFFFF;

   // operation codes
   localparam logic [1:0] OP_DICT      = 2'd0;
   localparam logic [1:0] OP_TEXT      = 2'd1;
   localparam logic [1:0] OP_CLEAR     = 2'd2;
   localparam logic [1:0] OP_CLEAR_ALT = 2'd3;

   // result status codes
   localparam logic [1:0] STAT_TEXT    = 2'd0;
   localparam logic [1:0] STAT_TAKEN   = 2'd1;
   localparam logic [1:0] STAT_DROPPED = 2'd2;
   localparam logic [1:0] STAT_CLEARED = 2'd3;

   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] symbol;
      logic       word_end;
      logic       text_first;
   } req_type;

   typedef struct packed {
      logic [15:0] extra_count;
      logic [1:0]  status;
   } rsp_type;

   typedef struct packed {
      logic       write_char;
      logic       clear;
      logic [7:0] symbol;
      logic       word_end;
   } dict_cmd_type;

   typedef struct packed {
      logic char_shift;
      logic cost_shift;
      logic cost_clear;
   } cell_ctl_type;

endpackage

// ===== sv/mecwb_cell.sv =====
module mecwb_cell #(
   parameter int WORD_LEN = mecwb_pkg::WORD_LEN_DEF,
   parameter int INDEX = 0,
   localparam int LW = $clog2(WORD_LEN + 1),
   localparam int CLW = (WORD_LEN > 1) ? $clog2(WORD_LEN) : 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  mecwb_pkg::cell_ctl_type    ctl,
   input  logic [7:0]                 char_in,
   input  logic [15:0]                cost_in,
   output logic [7:0]                 char_out,
   output logic [15:0]                cost_out,
   input  logic [WORD_LEN-1:0][7:0]   row,
   input  logic [LW-1:0]              len,
   output logic                       match
);
   import mecwb_pkg::*;

   localparam logic [LW-1:0] KPOS = LW'(INDEX);
   localparam bit HEAD = (INDEX == 0);

   logic [7:0]  char_ff;
   logic [15:0] cost_ff;
   logic        active;
   logic [LW-1:0] pos;

   always_ff @(posedge clock) begin
      if (reset) begin
         char_ff <= '0;
         cost_ff <= '0;
      end else begin
         if (ctl.char_shift) begin
            char_ff <= char_in;
         end
         if (ctl.cost_shift) begin
            cost_ff <= cost_in;
         end else if (ctl.cost_clear && HEAD) begin
            cost_ff <= '0;
         end
      end
   end

   // this cell holds the char that sits len-1-INDEX places into the word
   assign active = KPOS < len;
   assign pos = len - KPOS - LW'(1);
   assign match = !active || (row[pos[CLW-1:0]] == char_ff);

   assign char_out = char_ff;
   assign cost_out = cost_ff;

endmodule

// ===== sv/mecwb_dict.sv =====
module mecwb_dict #(
   parameter int DICT_WORDS = mecwb_pkg::DICT_WORDS_DEF,
   parameter int WORD_LEN = mecwb_pkg::WORD_LEN_DEF,
   localparam int CW = $clog2(DICT_WORDS + 1),
   localparam int AW = (DICT_WORDS > 1) ? $clog2(DICT_WORDS) : 1,
   localparam int LW = $clog2(WORD_LEN + 1),
   localparam int CLW = (WORD_LEN > 1) ? $clog2(WORD_LEN) : 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  mecwb_pkg::dict_cmd_type    cmd,
   output logic [1:0]                 status,
   input  logic                       rd_en,
   input  logic [AW-1:0]              rd_addr,
   output logic [WORD_LEN-1:0][7:0]   rd_row,
   output logic [LW-1:0]              rd_len,
   output logic [CW-1:0]              word_count
);
   import mecwb_pkg::*;

   logic [WORD_LEN-1:0][7:0] word_chars_ff [DICT_WORDS];
   logic [LW-1:0]            word_lengths_ff [DICT_WORDS];

   logic [CW-1:0] word_count_ff, word_count_in;
   logic [LW-1:0] build_length_ff, build_length_in;
   logic          build_overflow_ff, build_overflow_in;
   logic [WORD_LEN-1:0][7:0] rd_row_ff;
   logic [LW-1:0] rd_len_ff;

   logic          full, long_word, drop_char, overflow_next, word_ok;
   logic          char_we, len_we;
   logic [LW-1:0] length_next;
   logic [AW-1:0] waddr;

   always_comb begin
      full = word_count_ff == CW'(DICT_WORDS);
      long_word = build_length_ff == LW'(WORD_LEN);
      drop_char = full || long_word;
      overflow_next = build_overflow_ff || drop_char;
      length_next = drop_char ? build_length_ff : build_length_ff + LW'(1);
      word_ok = !overflow_next && (length_next != '0) && !full;
      char_we = cmd.write_char && !drop_char;
      len_we = cmd.write_char && cmd.word_end && word_ok;
      waddr = word_count_ff[AW-1:0];

      status = drop_char ? STAT_DROPPED : STAT_TAKEN;
      if (cmd.word_end && !word_ok) begin
         status = STAT_DROPPED;
      end

      word_count_in = word_count_ff;
      build_length_in = build_length_ff;
      build_overflow_in = build_overflow_ff;
      if (cmd.clear) begin
         word_count_in = '0;
         build_length_in = '0;
         build_overflow_in = 1'b0;
      end else if (cmd.write_char) begin
         if (cmd.word_end) begin
            build_length_in = '0;
            build_overflow_in = 1'b0;
            if (word_ok) begin
               word_count_in = word_count_ff + CW'(1);
            end
         end else begin
            build_length_in = length_next;
            build_overflow_in = overflow_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_count_ff <= '0;
         build_length_ff <= '0;
         build_overflow_ff <= 1'b0;
      end else begin
         word_count_ff <= word_count_in;
         build_length_ff <= build_length_in;
         build_overflow_ff <= build_overflow_in;
      end
   end

   // word table, one row per word, byte lane write
   always_ff @(posedge clock) begin
      if (char_we) begin
         word_chars_ff[waddr][build_length_ff[CLW-1:0]] <= cmd.symbol;
      end
      if (len_we) begin
         word_lengths_ff[waddr] <= length_next;
      end
      if (rd_en) begin
         rd_row_ff <= word_chars_ff[rd_addr];
         rd_len_ff <= word_lengths_ff[rd_addr];
      end
   end

   assign rd_row = rd_row_ff;
   assign rd_len = rd_len_ff;
   assign word_count = word_count_ff;

endmodule

// ===== sv/min_extra_chars_word_break_top.sv =====
// dictionary and clear transfers: result registered in the cycle after the transfer,
//   one such item per cycle while the result side keeps up
// text transfers: S_SCAN reads every stored word, S_FINISH then writes the result; no new
//   item is taken until it is written; the word table read port reads one stored word per cycle
// reset (synchronous, active high) empties the word table and starts an empty text
module min_extra_chars_word_break_top #(
   parameter int DICT_WORDS = mecwb_pkg::DICT_WORDS_DEF,
   parameter int WORD_LEN = mecwb_pkg::WORD_LEN_DEF,
   localparam int CW = $clog2(DICT_WORDS + 1),
   localparam int AW = (DICT_WORDS > 1) ? $clog2(DICT_WORDS) : 1,
   localparam int LW = $clog2(WORD_LEN + 1),
   localparam int CLW = (WORD_LEN > 1) ? $clog2(WORD_LEN) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  mecwb_pkg::req_type   req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output mecwb_pkg::rsp_type   rsp_data
);
   import mecwb_pkg::*;

   // one-hot sequencer: idle, scan of the word table, result write
   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_SCAN   = 3'b010,
      S_FINISH = 3'b100
   } state_type;

   state_type     state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff, rsp_data_in;
   logic [CW-1:0] scan_count_ff, scan_count_in;
   logic          rd_valid_ff, rd_valid_in;
   logic [LW-1:0] seen_ff, seen_in;
   logic [LW-1:0] scan_seen_ff, scan_seen_in;
   logic [15:0]   best_ff, best_in;

   logic          slot_free, accept;
   logic          op_dict, op_text, op_clear;
   dict_cmd_type  dict_cmd;
   logic [1:0]    dict_status;
   logic          rd_en;
   logic [WORD_LEN-1:0][7:0] rd_row;
   logic [LW-1:0] rd_len, len_m1;
   logic [CW-1:0] word_count;
   cell_ctl_type  cell_ctl;
   logic [15:0]   cost_first, sel_cost;
   logic          hit;

   logic [7:0]          char_vec [WORD_LEN];
   logic [15:0]         cost_vec [WORD_LEN];
   logic [WORD_LEN-1:0] match_vec;

   // output register parts the two sides: a new transfer is taken while the
   // result waits, as long as it is drained in the same cycle
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && slot_free;
   assign accept = req_valid && req_ready;

   // operation decode, the spare code clears like the regular clear
   always_comb begin
      op_dict = 1'b0;
      op_text = 1'b0;
      op_clear = 1'b0;
      unique case (req_data.operation) inside
         OP_DICT: op_dict = 1'b1;
         OP_TEXT: op_text = 1'b1;
         OP_CLEAR, OP_CLEAR_ALT: op_clear = 1'b1;
      endcase
   end

   always_comb begin
      dict_cmd.write_char = accept && op_dict;
      dict_cmd.clear = accept && op_clear;
      dict_cmd.symbol = req_data.symbol;
      dict_cmd.word_end = req_data.word_end;
   end

   // word table and word builder
   mecwb_dict #(
      .DICT_WORDS (DICT_WORDS),
      .WORD_LEN   (WORD_LEN)
   ) u_dict (
      .clock      (clock),
      .reset      (reset),
      .cmd        (dict_cmd),
      .status     (dict_status),
      .rd_en      (rd_en),
      .rd_addr    (scan_count_ff[AW-1:0]),
      .rd_row     (rd_row),
      .rd_len     (rd_len),
      .word_count (word_count)
   );

   // row of history cells: cell k keeps the k-th newest text char and the cost
   // k places back; chars move in on the transfer, costs at the result
   genvar k;
   generate
      for (k = 0; k < WORD_LEN; k++) begin : g_cell
         logic [7:0]  char_in;
         logic [15:0] cost_in;
         if (k == 0) begin : g_head
            assign char_in = req_data.symbol;
            assign cost_in = best_ff;
         end else begin : g_body
            assign char_in = char_vec[k-1];
            assign cost_in = cost_vec[k-1];
         end
         mecwb_cell #(
            .WORD_LEN (WORD_LEN),
            .INDEX    (k)
         ) u_cell (
            .clock    (clock),
            .reset    (reset),
            .ctl      (cell_ctl),
            .char_in  (char_in),
            .cost_in  (cost_in),
            .char_out (char_vec[k]),
            .cost_out (cost_vec[k]),
            .row      (rd_row),
            .len      (rd_len),
            .match    (match_vec[k])
         );
      end
   endgenerate

   // word just read ends here when every cell agrees and the text is long enough
   always_comb begin
      rd_en = (state_ff == S_SCAN) && (scan_count_ff < word_count);
      len_m1 = rd_len - LW'(1);
      sel_cost = cost_vec[len_m1[CLW-1:0]];
      hit = rd_valid_ff && (rd_len != '0) && (len_m1 <= scan_seen_ff) &&
            (&match_vec) && (sel_cost < best_ff);
      cost_first = req_data.text_first ? 16'd0 : cost_vec[0];
   end

   always_comb begin
      state_in = state_ff;
      scan_count_in = scan_count_ff;
      rd_valid_in = rd_en;
      best_in = best_ff;
      scan_seen_in = scan_seen_ff;
      seen_in = seen_ff;
      cell_ctl.char_shift = accept && op_text;
      cell_ctl.cost_clear = accept && op_text && req_data.text_first;
      cell_ctl.cost_shift = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept && op_text) begin
               state_in = S_SCAN;
               scan_count_in = '0;
               scan_seen_in = req_data.text_first ? '0 : seen_ff;
               // skipping this char is the starting bid
               best_in = (cost_first == COST_MAX) ? COST_MAX : cost_first + 16'd1;
            end
         end
         S_SCAN: begin
            if (rd_en) begin
               scan_count_in = scan_count_ff + CW'(1);
            end
            if (hit) begin
               best_in = sel_cost;
            end
            // all words issued, the last read is checked in this cycle
            if (!rd_en) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (slot_free) begin
               cell_ctl.cost_shift = 1'b1;
               seen_in = (scan_seen_ff == LW'(WORD_LEN)) ? scan_seen_ff
                                                         : scan_seen_ff + LW'(1);
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in = rsp_data_ff;
      if (accept && !op_text) begin
         rsp_valid_in = 1'b1;
         rsp_data_in.extra_count = '0;
         rsp_data_in.status = op_dict ? dict_status : STAT_CLEARED;
      end else if ((state_ff == S_FINISH) && slot_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in.extra_count = best_ff;
         rsp_data_in.status = STAT_TEXT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         scan_count_ff <= '0;
         rd_valid_ff <= 1'b0;
         seen_ff <= '0;
         scan_seen_ff <= '0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         scan_count_ff <= scan_count_in;
         rd_valid_ff <= rd_valid_in;
         seen_ff <= seen_in;
         scan_seen_ff <= scan_seen_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      best_ff <= best_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

`ifndef SYNTHESIS
   // a table read in flight belongs to a scan
   a_read_in_scan: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> (state_ff == S_SCAN))
      else $error("word table read outside of a scan");

   // the scan pointer never passes the number of stored words
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (scan_count_ff <= word_count))
      else $error("scan pointer beyond stored words");

   // word table never holds more than its slots
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      word_count <= CW'(DICT_WORDS))
      else $error("word count beyond table size");

   // a text transfer always starts a scan
   a_text_scan: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_data.operation == OP_TEXT)) |=> (state_ff == S_SCAN))
      else $error("text transfer did not start a scan");
`endif

endmodule
